// ===== hdl/ggsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ggsr_pkg
// Shared types, codes and helpers for the greedy grid step router.
// ----------------------------------------------------------------------------
package ggsr_pkg;

  localparam int GRID_SIDE = 64;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DIST_W    = 14;
  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam logic [COORD_W-1:0] LIM_MAX = COORD_W'(GRID_SIDE - 2);

  typedef enum logic [1:0] {
    MARK_OPEN    = 2'd0,
    MARK_WALL    = 2'd1,
    MARK_VISITED = 2'd2,
    MARK_SPARE   = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    ACT_PLACE = 2'd0,
    ACT_WALL  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } in_t;

  typedef struct packed {
    logic [2:0]         direction;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               reached;
    logic               stuck;
    logic [STEP_W-1:0]  steps_taken;
  } out_t;

  // one neighbour under evaluation, aligned with the memory read data
  typedef struct packed {
    logic              valid;
    logic [2:0]        dir;
    logic              in_grid;
    logic [DIST_W-1:0] dist_sq;
  } cand_t;

  // heading order N, NE, E, SE, S, SW, W, NW; N is y+1
  function automatic logic signed [1:0] dir_dx(input logic [2:0] p);
    logic signed [1:0] d;
    unique case (p)
      3'd1, 3'd2, 3'd3: d = 2'sd1;
      3'd5, 3'd6, 3'd7: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] p);
    logic signed [1:0] d;
    unique case (p)
      3'd7, 3'd0, 3'd1: d = 2'sd1;
      3'd3, 3'd4, 3'd5: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] lim_of(input logic [COORD_W-1:0] v);
    return (v > LIM_MAX) ? LIM_MAX : v;
  endfunction

  function automatic logic in_interior(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] w,
                                       input logic [COORD_W-1:0] h);
    return (x != '0) && (y != '0) && (x <= lim_of(w)) && (y <= lim_of(h));
  endfunction

endpackage

// ===== hdl/ggsr_nbr_eval.sv =====
// ----------------------------------------------------------------------------
// ggsr_nbr_eval
// Neighbour address, interior check and squared distance to the target for
// one heading; the candidate is registered to line up with the read data.
// ----------------------------------------------------------------------------
module ggsr_nbr_eval (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   issue,
  input  logic [2:0]             dir,
  input  logic [ggsr_pkg::COORD_W-1:0] walk_x,
  input  logic [ggsr_pkg::COORD_W-1:0] walk_y,
  input  logic [ggsr_pkg::COORD_W-1:0] tgt_x,
  input  logic [ggsr_pkg::COORD_W-1:0] tgt_y,
  input  logic [ggsr_pkg::COORD_W-1:0] grid_w,
  input  logic [ggsr_pkg::COORD_W-1:0] grid_h,
  output logic [ggsr_pkg::ADDR_W-1:0]  rd_addr,
  output ggsr_pkg::cand_t              cand_r
);
  import ggsr_pkg::*;

  logic signed [1:0]         sx, sy;
  logic signed [COORD_W+1:0] nx, ny, ddx, ddy;
  logic signed [15:0]        ddx16, ddy16, sqx, sqy;
  logic [15:0]               dsum;
  logic                      x_ok, y_ok;

  always_comb begin
    sx    = dir_dx(dir);
    sy    = dir_dy(dir);
    nx    = $signed({2'b00, walk_x}) + {{COORD_W{sx[1]}}, sx};
    ny    = $signed({2'b00, walk_y}) + {{COORD_W{sy[1]}}, sy};
    x_ok  = !nx[COORD_W+1] && (nx != '0) && (nx[COORD_W:0] <= {1'b0, lim_of(grid_w)});
    y_ok  = !ny[COORD_W+1] && (ny != '0) && (ny[COORD_W:0] <= {1'b0, lim_of(grid_h)});
    ddx   = nx - $signed({2'b00, tgt_x});
    ddy   = ny - $signed({2'b00, tgt_y});
    ddx16 = 16'(ddx);
    ddy16 = 16'(ddy);
    sqx   = ddx16 * ddx16;
    sqy   = ddy16 * ddy16;
    dsum  = 16'(sqx + sqy);
    rd_addr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.valid <= 1'b0;
    end else begin
      cand_r.valid <= issue;
    end
    cand_r.dir     <= dir;
    cand_r.in_grid <= x_ok && y_ok;
    cand_r.dist_sq <= dsum[DIST_W-1:0];
  end

endmodule

// ===== hdl/greedy_grid_step_router.sv =====
// ----------------------------------------------------------------------------
// greedy_grid_step_router
// Grid of cell marks in one synchronous RAM with a walker that takes greedy
// 8-neighbour steps towards a configured target.
// ----------------------------------------------------------------------------
//  channel  | ports                         | beat
//  ---------+-------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data   | action, cell_x, cell_y
//  result   | out_valid, out_ready, out_data| direction, pos, flags, steps
//  config   | cfg_we, cfg_addr, cfg_wdata   | one register write per cycle
//
//  Step: accept, eight mark RAM reads, a drain state, reply.
//  Wall, no-op and refused step: accept, then reply. Placement: accept, the
//  clearing sweep of the 4096-entry mark RAM, one entry per cycle, reply.
//  After reset the same sweep of all 4096 entries runs before in_ready rises.
//  One item at a time; a held result stalls only the end of the next item.
// ----------------------------------------------------------------------------
module greedy_grid_step_router (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ggsr_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ggsr_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [ggsr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ggsr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import ggsr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_REPLY
  } state_t;

  state_t             state_r;
  logic [COORD_W-1:0] grid_w_r, grid_h_r, tgt_x_r, tgt_y_r;
  logic [STEP_W-1:0]  limit_r, steps_r;
  logic [COORD_W-1:0] walk_x_r, walk_y_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic               clr_reply_r;
  logic [3:0]         scan_p_r;
  logic               found_r, found_nxt;
  logic [DIST_W-1:0]  best_d_r, best_d_nxt;
  logic [2:0]         best_p_r, best_p_nxt;
  logic [2:0]         dir_r;
  logic               stuck_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               in_fire, on_target, walk_inside, scan_end, take;
  logic signed [1:0]  mv_dx, mv_dy;
  logic [ADDR_W-1:0]  rd_addr;
  cand_t              cand_r;

  logic [1:0]         mem [GRID_SIDE*GRID_SIDE];
  logic [1:0]         mem_rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [1:0]         mem_wdata;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign on_target   = (walk_x_r == tgt_x_r) && (walk_y_r == tgt_y_r);
  assign walk_inside = in_interior(walk_x_r, walk_y_r, grid_w_r, grid_h_r);
  assign scan_end    = (state_r == ST_SCAN) && scan_p_r[3];
  assign mv_dx       = dir_dx(best_p_nxt);
  assign mv_dy       = dir_dy(best_p_nxt);

  ggsr_nbr_eval u_nbr (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   ((state_r == ST_SCAN) && !scan_p_r[3]),
    .dir     (scan_p_r[2:0]),
    .walk_x  (walk_x_r),
    .walk_y  (walk_y_r),
    .tgt_x   (tgt_x_r),
    .tgt_y   (tgt_y_r),
    .grid_w  (grid_w_r),
    .grid_h  (grid_h_r),
    .rd_addr (rd_addr),
    .cand_r  (cand_r)
  );

  // best open neighbour so far; ties keep the earlier heading
  always_comb begin
    take = cand_r.valid && cand_r.in_grid && (mem_rdata_r == MARK_OPEN) &&
           (!found_r || (cand_r.dist_sq < best_d_r));
    found_nxt  = found_r || take;
    best_d_nxt = take ? cand_r.dist_sq : best_d_r;
    best_p_nxt = take ? cand_r.dir  : best_p_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = MARK_OPEN;
    priority if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_fire && (in_data.action == ACT_WALL) &&
                 in_interior(in_data.cell_x, in_data.cell_y, grid_w_r, grid_h_r)) begin
      mem_we    = 1'b1;
      mem_waddr = {in_data.cell_y, in_data.cell_x};
      mem_wdata = MARK_WALL;
    end else if (scan_end && found_nxt && walk_inside) begin
      mem_we    = 1'b1;
      mem_waddr = {walk_y_r, walk_x_r};
      mem_wdata = MARK_VISITED;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= COORD_W'(8);
      grid_h_r <= COORD_W'(8);
      tgt_x_r  <= COORD_W'(1);
      tgt_y_r  <= COORD_W'(1);
      limit_r  <= STEP_W'(24);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WIDTH:  grid_w_r <= cfg_wdata[COORD_W-1:0];
        CFG_HEIGHT: grid_h_r <= cfg_wdata[COORD_W-1:0];
        CFG_TGT_X:  tgt_x_r  <= cfg_wdata[COORD_W-1:0];
        CFG_TGT_Y:  tgt_y_r  <= cfg_wdata[COORD_W-1:0];
        CFG_LIMIT:  limit_r  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_x_r    <= COORD_W'(1);
      walk_y_r    <= COORD_W'(1);
      steps_r     <= '0;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      scan_p_r    <= '0;
      found_r     <= 1'b0;
      best_d_r    <= '0;
      best_p_r    <= '0;
      dir_r       <= '0;
      stuck_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_REPLY)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            dir_r   <= '0;
            stuck_r <= (in_data.action == ACT_STEP) && (steps_r >= limit_r);
            unique case (in_data.action)
              ACT_PLACE: begin
                steps_r     <= '0;
                clr_addr_r  <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= ST_CLEAR;
                if (in_interior(in_data.cell_x, in_data.cell_y, grid_w_r, grid_h_r)) begin
                  walk_x_r <= in_data.cell_x;
                  walk_y_r <= in_data.cell_y;
                end
              end
              ACT_STEP: begin
                priority if (steps_r >= limit_r) begin
                  state_r <= ST_REPLY;
                end else if (on_target) begin
                  state_r <= ST_REPLY;
                end else begin
                  scan_p_r <= '0;
                  found_r  <= 1'b0;
                  state_r  <= ST_SCAN;
                end
              end
              ACT_WALL, ACT_NOP: begin
                state_r <= ST_REPLY;
              end
              default: state_r <= ST_REPLY;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            state_r <= clr_reply_r ? ST_REPLY : ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_p_r <= scan_p_r + 1'b1;
          found_r  <= found_nxt;
          best_d_r <= best_d_nxt;
          best_p_r <= best_p_nxt;
          if (scan_p_r[3]) begin
            if (found_nxt) begin
              walk_x_r <= walk_x_r + {{(COORD_W-2){mv_dx[1]}}, mv_dx};
              walk_y_r <= walk_y_r + {{(COORD_W-2){mv_dy[1]}}, mv_dy};
              dir_r    <= best_p_nxt;
              if (steps_r != '1) begin
                steps_r <= steps_r + 1'b1;
              end
            end else begin
              stuck_r <= 1'b1;
            end
            state_r <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.direction   <= dir_r;
            out_data_r.pos_x       <= walk_x_r;
            out_data_r.pos_y       <= walk_y_r;
            out_data_r.reached     <= on_target;
            out_data_r.stuck       <= stuck_r;
            out_data_r.steps_taken <= steps_r;
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // no mark write may land while neighbour reads are in flight
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && !scan_p_r[3]) |-> !mem_we)
    else $error("mark write during neighbour scan");

  // candidate heading is the one issued in the cycle before
  a_cand_align: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && cand_r.valid) |-> (cand_r.dir == 3'(scan_p_r - 1'b1)))
    else $error("candidate misaligned with read data");

  // a move changes the x coordinate by at most one
  a_one_cell_move: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_end && found_nxt) |=>
      ((6'(walk_x_r - $past(walk_x_r)) == 6'd0) || (6'(walk_x_r - $past(walk_x_r)) == 6'd1) ||
       (6'(walk_x_r - $past(walk_x_r)) == 6'h3f)))
    else $error("walker jumped more than one column");

  // the step counter only moves on placement or a successful step
  a_steps_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_REPLY) || (state_r == ST_CLEAR)) |=> $stable(steps_r))
    else $error("step count changed outside a step");

endmodule
